/* rtl/ogfsm_pkg.sv */
package ogfsm_pkg;

    localparam int COORD_BITS    = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CELLS_PM  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FREE_STEP = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT     = 3'd6;

    localparam logic [1:0] CMD_POSE  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_NOT_METRIC = 2'd1;
    localparam logic [1:0] ST_OUTSIDE    = 2'd2;

    localparam logic [1:0] JOB_STATUS = 2'd0;
    localparam logic [1:0] JOB_WALK   = 2'd1;
    localparam logic [1:0] JOB_CLEAR  = 2'd2;
    localparam logic [1:0] JOB_READ   = 2'd3;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [30:0]        cells_per_meter;
        logic [7:0]         grid_cols;
        logic [7:0]         grid_rows;
        logic [14:0]        free_step;
        logic [14:0]        log_odds_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            kind;
        logic [1:0]            status;
        logic [COORD_BITS-1:0] c0;
        logic [COORD_BITS-1:0] r0;
        logic [COORD_BITS-1:0] c1;
        logic [COORD_BITS-1:0] r1;
    } t_job;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         cells_updated;
        logic signed [15:0] cell_value;
        logic [14:0]        cells_observed;
    } t_res;

endpackage

/* rtl/ogfsm_fifo.sv */
module ogfsm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/ogfsm_front.sv */
module ogfsm_front #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogfsm_pkg::t_cfg     i_cfg,
    input  logic                i_accept,
    input  logic [1:0]          i_cmd,
    input  logic signed [31:0]  i_pose_x,
    input  logic signed [31:0]  i_pose_y,
    input  logic                i_pose_is_metric,
    input  logic [6:0]          i_read_col,
    input  logic [6:0]          i_read_row,
    output logic                o_busy,
    output logic                o_job_valid,
    output ogfsm_pkg::t_job     o_job,
    input  logic                i_job_full
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CONV   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_PUSH   = 2'd3;
    localparam int CB = ogfsm_pkg::COORD_BITS;

    logic [1:0]         r_state;
    logic               r_have_prior;
    logic signed [31:0] r_prior_x, r_prior_y, r_pose_x, r_pose_y;
    logic signed [32:0] r_d [4];
    logic signed [32:0] r_cell [4];
    logic [3:0]         r_step;
    logic signed [48:0] r_pp_lo, r_pp_hi;
    ogfsm_pkg::t_job    r_job;

    logic signed [32:0] sel;
    logic signed [16:0] part;
    logic signed [31:0] cpm_s;
    logic signed [48:0] pp;
    logic signed [64:0] sum;
    logic signed [32:0] conv_cell;
    logic [1:0]         store_idx;
    logic [31:0]        eff_c, eff_r;
    logic               cur_in, prior_in;

    assign o_busy      = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);
    assign o_job       = r_job;

    // 33x31 product split into two 17x32 partial products
    assign sel       = r_d[r_step[2:1]];
    assign part      = r_step[0] ? sel[32:16] : $signed({1'b0, sel[15:0]});
    assign cpm_s     = $signed({1'b0, i_cfg.cells_per_meter});
    assign pp        = part * cpm_s;
    assign sum       = $signed({r_pp_hi, 16'b0}) + 65'(r_pp_lo) + 65'sh0_8000_0000;
    assign conv_cell = sum[64:32];
    assign store_idx = 2'(r_step[3:1] - 3'd1);

    assign eff_c = (32'(i_cfg.grid_cols) > 32'(MAX_COLS)) ? 32'(MAX_COLS)
                                                          : 32'(i_cfg.grid_cols);
    assign eff_r = (32'(i_cfg.grid_rows) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                          : 32'(i_cfg.grid_rows);
    assign cur_in = !r_cell[0][32] && !r_cell[1][32] &&
                    (r_cell[0][31:0] < eff_c) && (r_cell[1][31:0] < eff_r);
    assign prior_in = r_have_prior && !r_cell[2][32] && !r_cell[3][32] &&
                      (r_cell[2][31:0] < eff_c) && (r_cell[3][31:0] < eff_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_prior <= 1'b0;
            r_prior_x    <= '0;
            r_prior_y    <= '0;
            r_step       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_job.c0 <= '0;
                        r_job.r0 <= '0;
                        r_job.c1 <= CB'(i_read_col);
                        r_job.r1 <= CB'(i_read_row);
                        case (i_cmd)
                            ogfsm_pkg::CMD_POSE: begin
                                if (i_pose_is_metric) begin
                                    r_d[0]   <= 33'(i_pose_x) - 33'(i_cfg.origin_x);
                                    r_d[1]   <= 33'(i_pose_y) - 33'(i_cfg.origin_y);
                                    r_d[2]   <= 33'(r_prior_x) - 33'(i_cfg.origin_x);
                                    r_d[3]   <= 33'(r_prior_y) - 33'(i_cfg.origin_y);
                                    r_pose_x <= i_pose_x;
                                    r_pose_y <= i_pose_y;
                                    r_step   <= '0;
                                    r_state  <= S_CONV;
                                end else begin
                                    r_job.kind   <= ogfsm_pkg::JOB_STATUS;
                                    r_job.status <= ogfsm_pkg::ST_NOT_METRIC;
                                    r_state      <= S_PUSH;
                                end
                            end
                            ogfsm_pkg::CMD_CLEAR: begin
                                r_have_prior <= 1'b0;
                                r_prior_x    <= '0;
                                r_prior_y    <= '0;
                                r_job.kind   <= ogfsm_pkg::JOB_CLEAR;
                                r_job.status <= ogfsm_pkg::ST_DONE;
                                r_state      <= S_PUSH;
                            end
                            ogfsm_pkg::CMD_READ: begin
                                r_job.kind   <= ogfsm_pkg::JOB_READ;
                                r_job.status <= ogfsm_pkg::ST_DONE;
                                r_state      <= S_PUSH;
                            end
                            default: begin
                                r_job.kind   <= ogfsm_pkg::JOB_STATUS;
                                r_job.status <= ogfsm_pkg::ST_DONE;
                                r_state      <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    if (!r_step[0] && (r_step != 4'd0)) begin
                        r_cell[store_idx] <= conv_cell;
                    end
                    if (r_step[0]) begin
                        r_pp_hi <= pp;
                    end else begin
                        r_pp_lo <= pp;
                    end
                    if (r_step == 4'd8) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_job.c1 <= r_cell[0][CB-1:0];
                    r_job.r1 <= r_cell[1][CB-1:0];
                    r_job.c0 <= prior_in ? r_cell[2][CB-1:0] : r_cell[0][CB-1:0];
                    r_job.r0 <= prior_in ? r_cell[3][CB-1:0] : r_cell[1][CB-1:0];
                    if (cur_in) begin
                        r_job.kind   <= ogfsm_pkg::JOB_WALK;
                        r_job.status <= ogfsm_pkg::ST_DONE;
                        r_have_prior <= 1'b1;
                        r_prior_x    <= r_pose_x;
                        r_prior_y    <= r_pose_y;
                    end else begin
                        r_job.kind   <= ogfsm_pkg::JOB_STATUS;
                        r_job.status <= ogfsm_pkg::ST_OUTSIDE;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_job_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/ogfsm_back.sv */
module ogfsm_back #(
    parameter int MAX_COLS      = 128,
    parameter int MAX_ROWS      = 128,
    parameter int LOG_ODDS_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ogfsm_pkg::t_cfg i_cfg,
    input  logic            i_job_empty,
    input  ogfsm_pkg::t_job i_job,
    output logic            o_job_pop,
    output logic            o_init,
    output logic            o_res_valid,
    output ogfsm_pkg::t_res o_res,
    input  logic            i_res_full
);
    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_WALK = 3'd2;
    localparam logic [2:0] B_READ = 3'd3;
    localparam logic [2:0] B_EMIT = 3'd4;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = ((CW > RW) ? CW : RW) + 3;
    localparam int LB    = LOG_ODDS_BITS;
    localparam int VW    = ((LB > 16) ? LB : 16) + 2;
    localparam longint CAP = (64'sd1 <<< (LB - 1)) - 64'sd1;
    localparam logic signed [VW-1:0] CAP_V = VW'(CAP);

    logic [LB-1:0]        r_mem [DEPTH];
    logic signed [LB-1:0] r_rdata;

    logic [2:0]           r_state;
    logic                 r_init;
    logic [AW-1:0]        r_clr_addr;
    logic [CW-1:0]        r_c, r_c1;
    logic [RW-1:0]        r_r, r_r1;
    logic signed [EW-1:0] r_dc, r_dr, r_err;
    logic                 r_sc, r_sr, r_live, r_pv, r_rd_ok;
    logic [AW-1:0]        r_paddr;
    logic [7:0]           r_upd;
    logic [14:0]          r_obs;
    ogfsm_pkg::t_res      r_res;

    logic [AW-1:0]        rd_addr, wr_addr;
    logic [LB-1:0]        wr_data;
    logic                 wr_en;
    logic signed [EW-1:0] c0e, c1e, r0e, r1e, e2;
    logic                 at_end, step_c, step_r;
    logic signed [VW-1:0] prev, fs_s, lim_s, lim_n, nx, nx_c;
    logic                 changed;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                input logic [RW-1:0] r);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    assign o_init      = r_init;
    assign o_job_pop   = (r_state == B_IDLE) && !i_job_empty;
    assign o_res_valid = (r_state == B_EMIT);
    assign o_res       = r_res;

    assign c0e = $signed(EW'(i_job.c0[CW-1:0]));
    assign c1e = $signed(EW'(i_job.c1[CW-1:0]));
    assign r0e = $signed(EW'(i_job.r0[RW-1:0]));
    assign r1e = $signed(EW'(i_job.r1[RW-1:0]));

    assign at_end = (r_c == r_c1) && (r_r == r_r1);
    assign e2     = r_err <<< 1;
    assign step_c = (e2 >= r_dr);
    assign step_r = (e2 <= r_dc);

    assign prev    = VW'(r_rdata);
    assign fs_s    = $signed(VW'(i_cfg.free_step));
    assign lim_s   = ($signed(VW'(i_cfg.log_odds_limit)) > CAP_V) ? CAP_V
                                                               : $signed(VW'(i_cfg.log_odds_limit));
    assign lim_n   = -lim_s;
    assign nx      = prev - fs_s;
    assign nx_c    = (nx < lim_n) ? lim_n : ((nx > lim_s) ? lim_s : nx);
    assign changed = (nx_c != prev);

    always_comb begin
        if (r_state == B_WALK) begin
            rd_addr = cell_addr(r_c, r_r);
        end else begin
            rd_addr = cell_addr(i_job.c1[CW-1:0], i_job.r1[RW-1:0]);
        end
        if (r_state == B_CLR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = (r_state == B_WALK) && r_pv && changed;
            wr_addr = r_paddr;
            wr_data = nx_c[LB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLR;
            r_init     <= 1'b1;
            r_clr_addr <= '0;
            r_live     <= 1'b0;
            r_pv       <= 1'b0;
            r_upd      <= '0;
            r_obs      <= '0;
        end else begin
            case (r_state)
                B_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        if (r_init) begin
                            r_init  <= 1'b0;
                            r_state <= B_IDLE;
                        end else begin
                            r_res   <= '{ogfsm_pkg::ST_DONE, 8'd0, 16'sd0, 15'd0};
                            r_state <= B_EMIT;
                        end
                    end
                end
                B_IDLE: begin
                    if (!i_job_empty) begin
                        case (i_job.kind)
                            ogfsm_pkg::JOB_STATUS: begin
                                r_res   <= '{i_job.status, 8'd0, 16'sd0, r_obs};
                                r_state <= B_EMIT;
                            end
                            ogfsm_pkg::JOB_CLEAR: begin
                                r_clr_addr <= '0;
                                r_obs      <= '0;
                                r_state    <= B_CLR;
                            end
                            ogfsm_pkg::JOB_READ: begin
                                r_rd_ok <= (32'(i_job.c1) < 32'(MAX_COLS)) &&
                                           (32'(i_job.r1) < 32'(MAX_ROWS));
                                r_state <= B_READ;
                            end
                            default: begin
                                r_c   <= i_job.c0[CW-1:0];
                                r_r   <= i_job.r0[RW-1:0];
                                r_c1  <= i_job.c1[CW-1:0];
                                r_r1  <= i_job.r1[RW-1:0];
                                r_dc  <= (c1e > c0e) ? c1e - c0e : c0e - c1e;
                                r_dr  <= (r1e > r0e) ? r0e - r1e : r1e - r0e;
                                r_err <= ((c1e > c0e) ? c1e - c0e : c0e - c1e) +
                                         ((r1e > r0e) ? r0e - r1e : r1e - r0e);
                                r_sc    <= (c0e < c1e);
                                r_sr    <= (r0e < r1e);
                                r_live  <= 1'b1;
                                r_pv    <= 1'b0;
                                r_upd   <= '0;
                                r_state <= B_WALK;
                            end
                        endcase
                    end
                end
                B_WALK: begin
                    // read of the next cell overlaps the update of the last one
                    r_pv    <= r_live;
                    r_paddr <= cell_addr(r_c, r_r);
                    if (r_live) begin
                        if (at_end) begin
                            r_live <= 1'b0;
                        end else begin
                            if (step_c) begin
                                r_c <= r_sc ? r_c + 1'b1 : r_c - 1'b1;
                            end
                            if (step_r) begin
                                r_r <= r_sr ? r_r + 1'b1 : r_r - 1'b1;
                            end
                            r_err <= r_err + (step_c ? r_dr : '0) + (step_r ? r_dc : '0);
                        end
                    end
                    if (r_pv && changed) begin
                        if (r_upd != 8'hFF) begin
                            r_upd <= r_upd + 1'b1;
                        end
                        if ((prev == '0) && (r_obs != 15'h7FFF)) begin
                            r_obs <= r_obs + 1'b1;
                        end
                    end
                    if (!r_live && !r_pv) begin
                        r_res   <= '{ogfsm_pkg::ST_DONE, r_upd, 16'sd0, r_obs};
                        r_state <= B_EMIT;
                    end
                end
                B_READ: begin
                    r_res   <= '{ogfsm_pkg::ST_DONE, 8'd0,
                                 (r_rd_ok ? 16'(r_rdata) : 16'sd0), r_obs};
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (!i_res_full) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

/* rtl/occupancy_grid_free_space_marker.sv */
// Occupancy grid free-space marker.
// Input side is a queue: drive the item fields with push; a beat is taken when
// push is high and full is low. Result side is a queue too: the oldest result
// sits on the o_ ports while empty is low and is taken with pop.
// Configuration: i_cfg_wen writes i_cfg_wdata to register i_cfg_addr at once;
// write only while the block is idle.
// Per item: a skipped pose or unused command passes the front's push state, the
// job queue, the back end's emit state and the result queue; a read also passes
// the back end's read state. The input reopens once the front hands off its job.
// A metric pose holds the front while it converts both ends of the line on one
// 17x32 multiplier, decides and hands off; then the walk does one cell
// read-modify-write per cycle, with dispatch, drain and hand-off around it.
// A clear command sweeps all MAX_COLS*MAX_ROWS words of the cell memory
// (16384 by default), one word per cycle.
// Reset: the same sweep runs after reset; full stays high until it is done.
// Configuration writes are taken during the sweep.
// A stalled receiver: two results fill the result queue and the back end holds
// the third, then two jobs queue between the front and back, then full stays high.
module occupancy_grid_free_space_marker #(
    parameter int MAX_COLS      = 128,
    parameter int MAX_ROWS      = 128,
    parameter int LOG_ODDS_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wen,
    input  logic [ogfsm_pkg::CFG_IDX_BITS-1:0]     i_cfg_addr,
    input  logic [ogfsm_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    input  logic                                   push,
    output logic                                   full,
    input  logic [1:0]                             i_cmd,
    input  logic signed [31:0]                     i_pose_x,
    input  logic signed [31:0]                     i_pose_y,
    input  logic                                   i_pose_is_metric,
    input  logic [6:0]                             i_read_col,
    input  logic [6:0]                             i_read_row,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [1:0]                             o_status,
    output logic [7:0]                             o_cells_updated,
    output logic signed [15:0]                     o_cell_value,
    output logic [14:0]                            o_cells_observed
);
    localparam int JW = $bits(ogfsm_pkg::t_job);
    localparam int RSW = $bits(ogfsm_pkg::t_res);

    ogfsm_pkg::t_cfg r_cfg;
    ogfsm_pkg::t_job fr_job, bk_job;
    ogfsm_pkg::t_res bk_res, out_res;
    logic            accept, fr_busy, fr_job_valid, job_full, job_empty, job_pop;
    logic            bk_init, bk_res_valid, res_full;
    logic [JW-1:0]   job_q;
    logic [RSW-1:0]  res_q;

    assign full   = fr_busy || bk_init;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{32'sd0, 32'sd0, 31'd655360, 8'd128, 8'd128, 15'd102, 15'd1024};
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                ogfsm_pkg::REG_ORIGIN_X:  r_cfg.origin_x        <= $signed(i_cfg_wdata);
                ogfsm_pkg::REG_ORIGIN_Y:  r_cfg.origin_y        <= $signed(i_cfg_wdata);
                ogfsm_pkg::REG_CELLS_PM:  r_cfg.cells_per_meter <= i_cfg_wdata[30:0];
                ogfsm_pkg::REG_GRID_COLS: r_cfg.grid_cols       <= i_cfg_wdata[7:0];
                ogfsm_pkg::REG_GRID_ROWS: r_cfg.grid_rows       <= i_cfg_wdata[7:0];
                ogfsm_pkg::REG_FREE_STEP: r_cfg.free_step       <= i_cfg_wdata[14:0];
                ogfsm_pkg::REG_LIMIT:     r_cfg.log_odds_limit  <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    ogfsm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (accept),
        .i_cmd            (i_cmd),
        .i_pose_x         (i_pose_x),
        .i_pose_y         (i_pose_y),
        .i_pose_is_metric (i_pose_is_metric),
        .i_read_col       (i_read_col),
        .i_read_row       (i_read_row),
        .o_busy           (fr_busy),
        .o_job_valid      (fr_job_valid),
        .o_job            (fr_job),
        .i_job_full       (job_full)
    );

    ogfsm_fifo #(
        .W     (JW),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_job_valid),
        .i_data  (fr_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_q),
        .o_empty (job_empty)
    );

    assign bk_job = job_q;

    ogfsm_back #(
        .MAX_COLS      (MAX_COLS),
        .MAX_ROWS      (MAX_ROWS),
        .LOG_ODDS_BITS (LOG_ODDS_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (bk_job),
        .o_job_pop   (job_pop),
        .o_init      (bk_init),
        .o_res_valid (bk_res_valid),
        .o_res       (bk_res),
        .i_res_full  (res_full)
    );

    ogfsm_fifo #(
        .W     (RSW),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_res_valid),
        .i_data  (bk_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign out_res          = res_q;
    assign o_status         = out_res.status;
    assign o_cells_updated  = out_res.cells_updated;
    assign o_cell_value     = out_res.cell_value;
    assign o_cells_observed = out_res.cells_observed;

endmodule

/* rtl/ogfsm_checker.sv */
module ogfsm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                full,
    input logic                                empty,
    input logic [1:0]                          o_status,
    input logic [7:0]                          o_cells_updated,
    input logic signed [15:0]                  o_cell_value
);
    // grid sweep after reset holds off input
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input open right after reset");

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present right after reset");

    a_skip_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ogfsm_pkg::ST_DONE) |-> (o_cells_updated == 8'd0))
        else $error("cells updated on a skipped pose");

    a_skip_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ogfsm_pkg::ST_DONE) |-> (o_cell_value == 16'sd0))
        else $error("cell value on a skipped pose");

endmodule

bind occupancy_grid_free_space_marker ogfsm_checker u_ogfsm_checker (.*);

/* verif/tb_occupancy_grid_free_space_marker.sv */
`timescale 1ns / 100ps

module tb_occupancy_grid_free_space_marker;

    localparam int GRID_DIM  = 128;
    localparam int IDLE_LIMIT = 60000;
    localparam int HOLD_CYCLES = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [ogfsm_pkg::CFG_IDX_BITS-1:0]  i_cfg_addr;
    logic [ogfsm_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic        push;
    logic        full;
    logic [1:0]  i_cmd;
    logic signed [31:0] i_pose_x;
    logic signed [31:0] i_pose_y;
    logic        i_pose_is_metric;
    logic [6:0]  i_read_col;
    logic [6:0]  i_read_row;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic [7:0]  o_cells_updated;
    logic signed [15:0] o_cell_value;
    logic [14:0] o_cells_observed;

    occupancy_grid_free_space_marker dut (.*);

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               metric;
        logic [6:0]         col;
        logic [6:0]         row;
        bit                 typed;
        ogfsm_pkg::t_res    res;
    } t_row;

    // grid model
    ogfsm_pkg::t_cfg grid_cfg;
    shortint       grid_cell [GRID_DIM*GRID_DIM];
    bit            have_prior;
    logic signed [31:0] prior_x, prior_y;
    int            observed_cnt;
    int            changed_cnt;

    ogfsm_pkg::t_res pending_res [$];
    t_row   dir_rows [$];
    int     errors = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    bit     hold_req = 0;
    bit     hold_done = 0;
    int     hold_left = 0;
    int     idle_cycles = 0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint cell_of(logic signed [31:0] pos, logic signed [31:0] org);
        longint d;
        longint p;
        d = longint'(pos) - longint'(org);
        p = d * longint'({33'b0, grid_cfg.cells_per_meter}) + 64'sh80000000;
        return p >>> 32;
    endfunction

    function automatic bit in_grid(longint c, longint r);
        longint nc;
        longint nr;
        nc = (grid_cfg.grid_cols > GRID_DIM) ? GRID_DIM : grid_cfg.grid_cols;
        nr = (grid_cfg.grid_rows > GRID_DIM) ? GRID_DIM : grid_cfg.grid_rows;
        return c >= 0 && r >= 0 && c < nc && r < nr;
    endfunction

    function automatic void mark_free(longint c, longint r);
        int lim;
        int prev;
        int nxt;
        int idx;
        if (!in_grid(c, r)) return;
        lim  = (grid_cfg.log_odds_limit < 32767) ? grid_cfg.log_odds_limit : 32767;
        idx  = int'(r) * GRID_DIM + int'(c);
        prev = grid_cell[idx];
        nxt  = prev - int'(grid_cfg.free_step);
        if (nxt < -lim) nxt = -lim;
        if (nxt > lim) nxt = lim;
        if (nxt != prev) begin
            if (prev == 0 && observed_cnt < 32767) observed_cnt++;
            grid_cell[idx] = shortint'(nxt);
            if (changed_cnt < 255) changed_cnt++;
        end
    endfunction

    function automatic void walk_free(longint c0, longint r0, longint c1, longint r1);
        longint dc;
        longint dr;
        longint sc;
        longint sr;
        longint err;
        longint e2;
        dc  = (c1 > c0) ? c1 - c0 : c0 - c1;
        dr  = -((r1 > r0) ? r1 - r0 : r0 - r1);
        sc  = (c0 < c1) ? 1 : -1;
        sr  = (r0 < r1) ? 1 : -1;
        err = dc + dr;
        forever begin
            mark_free(c0, r0);
            if (c0 == c1 && r0 == r1) break;
            e2 = 2 * err;
            if (e2 >= dr) begin
                err += dr;
                c0 += sc;
            end
            if (e2 <= dc) begin
                err += dc;
                r0 += sr;
            end
        end
    endfunction

    function automatic ogfsm_pkg::t_res grid_update(t_row it);
        ogfsm_pkg::t_res r;
        longint cc;
        longint cr;
        longint pc;
        longint pr;
        r = '0;
        changed_cnt = 0;
        case (it.cmd)
            ogfsm_pkg::CMD_POSE: begin
                if (!it.metric) begin
                    r.status = ogfsm_pkg::ST_NOT_METRIC;
                end else begin
                    cc = cell_of(it.px, grid_cfg.origin_x);
                    cr = cell_of(it.py, grid_cfg.origin_y);
                    if (!in_grid(cc, cr)) begin
                        r.status = ogfsm_pkg::ST_OUTSIDE;
                    end else begin
                        pc = cell_of(prior_x, grid_cfg.origin_x);
                        pr = cell_of(prior_y, grid_cfg.origin_y);
                        if (have_prior && in_grid(pc, pr)) walk_free(pc, pr, cc, cr);
                        else mark_free(cc, cr);
                        have_prior = 1;
                        prior_x = it.px;
                        prior_y = it.py;
                    end
                end
            end
            ogfsm_pkg::CMD_CLEAR: begin
                foreach (grid_cell[i]) grid_cell[i] = 0;
                have_prior = 0;
                prior_x = 0;
                prior_y = 0;
                observed_cnt = 0;
            end
            ogfsm_pkg::CMD_READ:
                r.cell_value = grid_cell[int'(it.row) * GRID_DIM + int'(it.col)];
            default: ;
        endcase
        r.cells_updated  = changed_cnt[7:0];
        r.cells_observed = observed_cnt[14:0];
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    task automatic check_beat();
        ogfsm_pkg::t_res want;
        if (pending_res.size() == 0) begin
            report("unexpected beat, status", o_status, -1);
            return;
        end
        want = pending_res.pop_front();
        if (o_status !== want.status) report("status", o_status, want.status);
        if (o_cells_updated !== want.cells_updated)
            report("cells_updated", o_cells_updated, want.cells_updated);
        if (o_cell_value !== want.cell_value)
            report("cell_value", o_cell_value, want.cell_value);
        if (o_cells_observed !== want.cells_observed)
            report("cells_observed", o_cells_observed, want.cells_observed);
    endtask

    // receiver, hold-off and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_beat();
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("** occupancy_grid_free_space_marker: FAILED **");
                $finish;
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic send(t_row it);
        ogfsm_pkg::t_res pred;
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_cmd            <= it.cmd;
        i_pose_x         <= it.px;
        i_pose_y         <= it.py;
        i_pose_is_metric <= it.metric;
        i_read_col       <= it.col;
        i_read_row       <= it.row;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pred = grid_update(it);
        pending_res.push_back(it.typed ? it.res : pred);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(ogfsm_pkg::t_cfg c);
        logic [ogfsm_pkg::CFG_DATA_BITS-1:0] val [7];
        val[ogfsm_pkg::REG_ORIGIN_X]  = c.origin_x;
        val[ogfsm_pkg::REG_ORIGIN_Y]  = c.origin_y;
        val[ogfsm_pkg::REG_CELLS_PM]  = {1'b0, c.cells_per_meter};
        val[ogfsm_pkg::REG_GRID_COLS] = {24'b0, c.grid_cols};
        val[ogfsm_pkg::REG_GRID_ROWS] = {24'b0, c.grid_rows};
        val[ogfsm_pkg::REG_FREE_STEP] = {17'b0, c.free_step};
        val[ogfsm_pkg::REG_LIMIT]     = {17'b0, c.log_odds_limit};
        for (int i = 0; i < 7; i++) begin
            i_cfg_wen   <= 1'b1;
            i_cfg_addr  <= ogfsm_pkg::CFG_IDX_BITS'(i);
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
        end
        i_cfg_wen <= 1'b0;
        grid_cfg = c;
    endtask

    function automatic t_row mk(logic [1:0] cmd, logic signed [31:0] px, logic signed [31:0] py,
                                logic metric, int col, int row);
        t_row it;
        it.cmd = cmd;
        it.px = px;
        it.py = py;
        it.metric = metric;
        it.col = 7'(col);
        it.row = 7'(row);
        it.typed = 0;
        it.res = '0;
        return it;
    endfunction

    function automatic t_row typed_row(t_row it, logic [1:0] st, int upd, int val, int obs);
        it.typed = 1;
        it.res.status = st;
        it.res.cells_updated = 8'(upd);
        it.res.cell_value = 16'(val);
        it.res.cells_observed = 15'(obs);
        return it;
    endfunction

    // world position landing in a given cell, with some jitter inside it
    function automatic logic signed [31:0] pose_for(longint cell_idx, logic signed [31:0] org);
        longint span;
        longint off;
        span = (longint'(1) <<< 32) / grid_cfg.cells_per_meter;
        off  = (cell_idx <<< 32) / grid_cfg.cells_per_meter - span / 2;
        if (span > 2) off += $urandom_range(0, (span > 32'h7fffffff) ? 32'h7fffffff : span - 1);
        return 32'(longint'(org) + off);
    endfunction

    function automatic t_row random_item();
        t_row    it;
        int      pick;
        longint  nc;
        longint  nr;
        it = mk(ogfsm_pkg::CMD_POSE, $urandom, $urandom, 1'b1, $urandom_range(0, 127),
                $urandom_range(0, 127));
        pick = $urandom_range(0, 999);
        nc = (grid_cfg.grid_cols > GRID_DIM) ? GRID_DIM : grid_cfg.grid_cols;
        nr = (grid_cfg.grid_rows > GRID_DIM) ? GRID_DIM : grid_cfg.grid_rows;
        if (pick < 750) begin
            it.px = pose_for(longint'($urandom_range(0, nc + 1)) - 1, grid_cfg.origin_x);
            it.py = pose_for(longint'($urandom_range(0, nr + 1)) - 1, grid_cfg.origin_y);
        end else if (pick < 800) begin
            it.metric = 1'b0;
        end else if (pick < 930) begin
            it.cmd = ogfsm_pkg::CMD_READ;
        end else if (pick < 950) begin
            it.cmd = ogfsm_pkg::CMD_SPARE;
        end else if (pick < 956) begin
            it.cmd = ogfsm_pkg::CMD_CLEAR;
        end
        return it;
    endfunction

    ogfsm_pkg::t_cfg phase_cfg [7];
    int   phase_items [7] = '{300, 150, 150, 100, 40, 60, 300};

    initial begin
        t_row it;
        int   sent;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        push = 1'b0;
        i_cmd = ogfsm_pkg::CMD_READ;
        i_pose_x = '0;
        i_pose_y = '0;
        i_pose_is_metric = 1'b0;
        i_read_col = '0;
        i_read_row = '0;
        grid_cfg = '{0, 0, 31'd655360, 8'd128, 8'd128, 15'd102, 15'd1024};
        foreach (grid_cell[i]) grid_cell[i] = 0;
        have_prior = 0;
        prior_x = 0;
        prior_y = 0;
        observed_cnt = 0;

        phase_cfg[0] = grid_cfg;
        phase_cfg[1] = '{32'sh80000000, 32'sh7fff0000, 31'd262144, 8'd40, 8'd17,
                         15'd32766, 15'd32767};
        phase_cfg[2] = '{32'shfff00000, 32'sh00012345, 31'h7fffffff, 8'd255, 8'd128,
                         15'd1, 15'd2};
        phase_cfg[3] = '{32'sh00001000, -32'sh00001000, 31'd1, 8'd1, 8'd1, 15'd200, 15'd100};
        phase_cfg[4] = '{0, 0, 31'd655360, 8'd0, 8'd128, 15'd102, 15'd1024};
        phase_cfg[5] = '{-32'sh00050000, 32'sh00030000, 31'd131072, 8'd128, 8'd200,
                         15'd0, 15'd0};
        phase_cfg[6] = '{32'sh00008000, 32'sh00008000, 31'd655360, 8'd128, 8'd128,
                         15'd102, 15'd1024};

        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_READ, 0, 0, 0, 0, 0),
                                     ogfsm_pkg::ST_DONE, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_READ, 0, 0, 0, 127, 127),
                                     ogfsm_pkg::ST_DONE, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_SPARE, -1, -1, 1, 127, 127),
                                     ogfsm_pkg::ST_DONE, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_POSE, 0, 0, 0, 0, 0),
                                     ogfsm_pkg::ST_NOT_METRIC, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_POSE, -32'sh10000, 0, 1, 0, 0),
                                     ogfsm_pkg::ST_OUTSIDE, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_POSE, 32'sh7fffffff, 32'sh7fffffff,
                                        1, 0, 0), ogfsm_pkg::ST_OUTSIDE, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_POSE, 32'sh80000000, 32'sh80000000,
                                        1, 0, 0), ogfsm_pkg::ST_OUTSIDE, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_POSE, 0, 0, 1, 0, 0),
                                     ogfsm_pkg::ST_DONE, 1, 0, 1));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_READ, 0, 0, 0, 0, 0),
                                     ogfsm_pkg::ST_DONE, 0, -102, 1));
        dir_rows.push_back(mk(ogfsm_pkg::CMD_POSE, 832307, 832307, 1, 0, 0));
        dir_rows.push_back(mk(ogfsm_pkg::CMD_READ, 0, 0, 0, 127, 127));
        dir_rows.push_back(mk(ogfsm_pkg::CMD_READ, 0, 0, 0, 64, 64));
        dir_rows.push_back(mk(ogfsm_pkg::CMD_POSE, 0, 832307, 1, 0, 0));
        dir_rows.push_back(mk(ogfsm_pkg::CMD_POSE, 0, 832307, 0, 0, 0));
        dir_rows.push_back(mk(ogfsm_pkg::CMD_POSE, 32'sh7fffffff, 0, 1, 0, 0));
        for (int i = 0; i < 12; i++)
            dir_rows.push_back(mk(ogfsm_pkg::CMD_POSE, 32768, 32768, 1, 0, 0));
        dir_rows.push_back(mk(ogfsm_pkg::CMD_READ, 0, 0, 0, 5, 5));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0),
                                     ogfsm_pkg::ST_DONE, 0, 0, 0));
        dir_rows.push_back(typed_row(mk(ogfsm_pkg::CMD_READ, 0, 0, 0, 5, 5),
                                     ogfsm_pkg::ST_DONE, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 9;
        recv_idle = 64;
        foreach (dir_rows[i]) send(dir_rows[i]);

        sent = 0;
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_cfg(phase_cfg[ph]);
            if (ph == 6) hold_req = 1;
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (sent == 370) begin
                    send_idle = 64;
                    recv_idle = 9;
                end else if (sent == 740) begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                it = random_item();
                send(it);
                sent++;
            end
        end
        drain();

        if (errors == 0 && pending_res.size() == 0) begin
            $display("** occupancy_grid_free_space_marker: PASSED **");
        end else begin
            if (pending_res.size() != 0)
                report("results never delivered", 0, pending_res.size());
            $display("** occupancy_grid_free_space_marker: FAILED **");
        end
        $finish;
    end

endmodule
